/* sv/lcdt_pkg.sv */
package lcdt_pkg;

    localparam int unsigned LINE_CYCLES   = 456;
    localparam int unsigned VISIBLE_LINES = 144;
    localparam int unsigned LAST_LINE     = 153;

    localparam int unsigned CNT_W    = 10;
    localparam int unsigned OAM_END  = 80;
    localparam int unsigned DRAW_END = 252;

    localparam logic [7:0] STAT_WR_MASK  = 8'hF8;
    localparam logic [7:0] STAT_KEEP     = 8'h07;
    localparam logic [7:0] STAT_RD_MASK  = 8'hFC;
    localparam logic [7:0] STAT_RD_SET   = 8'h80;
    localparam logic [7:0] BGP_RESET     = 8'hFC;
    localparam logic [7:0] UNDECODED_VAL = 8'hFF;

    localparam int unsigned STAT_LYC_FLAG = 2;
    localparam int unsigned STAT_HBL_EN   = 3;
    localparam int unsigned STAT_VBL_EN   = 4;
    localparam int unsigned STAT_OAM_EN   = 5;
    localparam int unsigned STAT_LYC_EN   = 6;
    localparam int unsigned LCDC_ON       = 7;

    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] address;
        logic [7:0]  cycles;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [7:0] line_now;
        logic [1:0] mode_now;
        logic [7:0] dma_source_page;
        logic       dma_start;
        logic       vblank_interrupt;
        logic       stat_interrupt;
        logic [7:0] render_line_number;
        logic       render_request;
        logic [7:0] read_data;
    } result_t;

    localparam int unsigned OUT_TDATA_W = ($bits(result_t) + 7) / 8 * 8;

endpackage

/* sv/lcdt_core.sv */
module lcdt_core
    import lcdt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    logic [7:0]       lcdc_reg, lcdc_next;
    logic [7:0]       stat_reg, stat_next;
    logic [7:0]       scy_reg, scy_next;
    logic [7:0]       scx_reg, scx_next;
    logic [7:0]       ly_reg, ly_next;
    logic [7:0]       lyc_reg, lyc_next;
    logic [7:0]       bgp_reg, bgp_next;
    logic [7:0]       obp0_reg, obp0_next;
    logic [7:0]       obp1_reg, obp1_next;
    logic [7:0]       wy_reg, wy_next;
    logic [7:0]       wx_reg, wx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mode_t            mode_reg, mode_next;
    mode_t            last_mode_reg, last_mode_next;

    logic [CNT_W:0] cnt_sum;
    logic [CNT_W:0] cnt_wrapped;
    logic [7:0]     line_inc;
    logic [7:0]     line_new;
    mode_t          mode_calc;

    assign cnt_sum     = {1'b0, cnt_reg} + (CNT_W + 1)'(item.cycles);
    assign cnt_wrapped = cnt_sum - (CNT_W + 1)'(LINE_CYCLES);
    assign line_inc    = ly_reg + 8'd1;
    assign line_new    = (line_inc > 8'(LAST_LINE)) ? 8'd0 : line_inc;

    always_comb begin
        if (ly_reg >= 8'(VISIBLE_LINES)) begin
            mode_calc = MODE_VBLANK;
        end else if (cnt_sum <= (CNT_W + 1)'(OAM_END)) begin
            mode_calc = MODE_OAM;
        end else if (cnt_sum <= (CNT_W + 1)'(DRAW_END)) begin
            mode_calc = MODE_DRAW;
        end else begin
            mode_calc = MODE_HBLANK;
        end
    end

    always_comb begin
        lcdc_next      = lcdc_reg;
        stat_next      = stat_reg;
        scy_next       = scy_reg;
        scx_next       = scx_reg;
        ly_next        = ly_reg;
        lyc_next       = lyc_reg;
        bgp_next       = bgp_reg;
        obp0_next      = obp0_reg;
        obp1_next      = obp1_reg;
        wy_next        = wy_reg;
        wx_next        = wx_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        last_mode_next = last_mode_reg;
        result         = '0;

        case (op_t'(item.operation))
            OP_TICK: begin
                if (!lcdc_reg[LCDC_ON]) begin
                    ly_next   = 8'd0;
                    mode_next = MODE_HBLANK;
                    cnt_next  = '0;
                end else begin
                    if (mode_calc != last_mode_reg) begin
                        mode_next      = mode_calc;
                        last_mode_next = mode_calc;
                        unique case (mode_calc)
                            MODE_HBLANK: begin
                                result.render_request     = 1'b1;
                                result.render_line_number = ly_reg;
                                result.stat_interrupt     = stat_reg[STAT_HBL_EN];
                            end
                            MODE_VBLANK: result.stat_interrupt = stat_reg[STAT_VBL_EN];
                            MODE_OAM:    result.stat_interrupt = stat_reg[STAT_OAM_EN];
                            default: ;
                        endcase
                    end
                    if (cnt_sum >= (CNT_W + 1)'(LINE_CYCLES)) begin
                        ly_next  = line_new;
                        cnt_next = cnt_wrapped[CNT_W-1:0];
                        if (line_new == lyc_reg) begin
                            stat_next[STAT_LYC_FLAG] = 1'b1;
                            if (stat_reg[STAT_LYC_EN]) begin
                                result.stat_interrupt = 1'b1;
                            end
                        end else begin
                            stat_next[STAT_LYC_FLAG] = 1'b0;
                        end
                        result.vblank_interrupt = (line_new == 8'(VISIBLE_LINES));
                    end else begin
                        cnt_next = cnt_sum[CNT_W-1:0];
                    end
                end
            end
            OP_WRITE: begin
                unique case (item.address)
                    ADDR_LCDC: lcdc_next = item.write_data;
                    ADDR_STAT: stat_next = (item.write_data & STAT_WR_MASK)
                                         | (stat_reg & STAT_KEEP);
                    ADDR_SCY:  scy_next  = item.write_data;
                    ADDR_SCX:  scx_next  = item.write_data;
                    ADDR_LY:   ly_next   = 8'd0;
                    ADDR_LYC:  lyc_next  = item.write_data;
                    ADDR_DMA: begin
                        result.dma_start       = 1'b1;
                        result.dma_source_page = item.write_data;
                    end
                    ADDR_BGP:  bgp_next  = item.write_data;
                    ADDR_OBP0: obp0_next = item.write_data;
                    ADDR_OBP1: obp1_next = item.write_data;
                    ADDR_WY:   wy_next   = item.write_data;
                    ADDR_WX:   wx_next   = item.write_data;
                    default: ;
                endcase
            end
            OP_READ: begin
                unique case (item.address)
                    ADDR_LCDC: result.read_data = lcdc_reg;
                    ADDR_STAT: result.read_data = (stat_reg & STAT_RD_MASK)
                                                | {6'd0, mode_reg} | STAT_RD_SET;
                    ADDR_SCY:  result.read_data = scy_reg;
                    ADDR_SCX:  result.read_data = scx_reg;
                    ADDR_LY:   result.read_data = ly_reg;
                    ADDR_LYC:  result.read_data = lyc_reg;
                    ADDR_BGP:  result.read_data = bgp_reg;
                    ADDR_OBP0: result.read_data = obp0_reg;
                    ADDR_OBP1: result.read_data = obp1_reg;
                    ADDR_WY:   result.read_data = wy_reg;
                    ADDR_WX:   result.read_data = wx_reg;
                    default:   result.read_data = UNDECODED_VAL;
                endcase
            end
            default: ;
        endcase

        result.mode_now = mode_next;
        result.line_now = ly_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcdc_reg      <= '0;
            stat_reg      <= '0;
            scy_reg       <= '0;
            scx_reg       <= '0;
            ly_reg        <= '0;
            lyc_reg       <= '0;
            bgp_reg       <= BGP_RESET;
            obp0_reg      <= '0;
            obp1_reg      <= '0;
            wy_reg        <= '0;
            wx_reg        <= '0;
            cnt_reg       <= '0;
            mode_reg      <= MODE_HBLANK;
            last_mode_reg <= MODE_HBLANK;
        end else if (advance) begin
            lcdc_reg      <= lcdc_next;
            stat_reg      <= stat_next;
            scy_reg       <= scy_next;
            scx_reg       <= scx_next;
            ly_reg        <= ly_next;
            lyc_reg       <= lyc_next;
            bgp_reg       <= bgp_next;
            obp0_reg      <= obp0_next;
            obp1_reg      <= obp1_next;
            wy_reg        <= wy_next;
            wx_reg        <= wx_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            last_mode_reg <= last_mode_next;
        end
    end

endmodule

/* sv/lcdt_outreg.sv */
module lcdt_outreg
    import lcdt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                result,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'(data_reg);

endmodule

/* sv/lcd_timing_and_registers.sv */
// channel | ports                        | word
// input   | s_tvalid s_tready s_tdata    | tdata: cycles, address, write_data
//         | s_tuser                      | tuser: operation
// result  | m_tvalid m_tready m_tdata    | tdata: read_data .. line_now
//
// One word per clock sustained while m_tready is held high; a word's result passes the input register,
// then the result register, whose output is m_tdata.
// Register state updates as the word moves from the input register to the result register.
// aresetn is synchronous; it empties both registers and restores the register file.
// A stalled result holds; the input register keeps taking a word while the result waits,
// until it is full.
module lcd_timing_and_registers
    import lcdt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,  // cycles[7:0], address[23:8], write_data[31:24]
    input  logic [1:0]             s_tuser,  // operation[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // read_data[7:0], render_request[8],
                                             // render_line_number[16:9], stat_interrupt[17],
                                             // vblank_interrupt[18], dma_start[19],
                                             // dma_source_page[27:20], mode_now[29:28],
                                             // line_now[37:30], zero[39:38]
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    advance;
    result_t result;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation  <= s_tuser;
            in_item_reg.cycles     <= s_tdata[7:0];
            in_item_reg.address    <= s_tdata[23:8];
            in_item_reg.write_data <= s_tdata[31:24];
        end
    end

    lcdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    lcdt_outreg u_outreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/lcdt_checker.sv */
module lcdt_checker
    import lcdt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_render_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[29:28] == MODE_HBLANK)
        else $error("render request outside HBlank");

    a_vblank_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[37:30] == 8'(VISIBLE_LINES))
        else $error("VBlank interrupt on wrong line");

    a_dma_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[19] |-> m_tdata[27:20] == 8'd0)
        else $error("DMA page without DMA start");

    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:30] <= 8'(LAST_LINE))
        else $error("scanline out of range");

endmodule

bind lcd_timing_and_registers lcdt_checker u_lcdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
